FILE: src/per_satellite_history_mean_core_macros.svh
// Assertion macros for the per-satellite history mean block.
`ifndef PER_SATELLITE_HISTORY_MEAN_CORE_MACROS_SVH
`define PER_SATELLITE_HISTORY_MEAN_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PSHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PSHM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PSHM_ASSERT(lbl, prop, msg)
`define PSHM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/pshm_pkg.sv
package pshm_pkg;

  localparam int CORR_W     = 32;
  localparam int SAT_W      = 6;
  localparam int CNT_OUT_W  = 4;
  localparam int CNT_OUT_MAX = 15;

  localparam int DEPTH_DEFAULT = 8;
  localparam int SLOTS_DEFAULT = 64;

  localparam logic signed [CORR_W-1:0] THRESH_RESET = -32'sd768000;

  // Input tdata: sat_id, correction.
  localparam int S_SAT_LO  = 0;
  localparam int S_CORR_LO = S_SAT_LO + SAT_W;
  localparam int S_TDATA_W = 40;

  // Output tdata: out_sat_id, mean_correction, sample_count.
  localparam int M_SAT_LO   = 0;
  localparam int M_MEAN_LO  = M_SAT_LO + SAT_W;
  localparam int M_CNT_LO   = M_MEAN_LO + CORR_W;
  localparam int M_USED_W   = M_CNT_LO + CNT_OUT_W;
  localparam int M_TDATA_W  = 48;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_EPOCH  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ABS,
    ST_ROUND,
    ST_DIV,
    ST_NEG,
    ST_DONE
  } state_e;

endpackage

FILE: src/per_satellite_history_mean_core.sv
// Per-satellite moving mean of pseudorange corrections.
// Input requests arrive on the s_axis channel. A sample request (tuser low) writes its
// correction into the current epoch column of its satellite and marks it valid when it
// is above the threshold; the block then returns the rounded mean of that satellite's
// valid entries and their count on the m_axis channel. An epoch request (tuser high)
// advances the column, clears its valid marks and returns nothing.
// Samples for slots at or above SATELLITE_SLOTS are dropped without a result.
// The threshold is loaded through the cfg channel, which is always ready.
// A sample's mean is computed with the shared adder, which first walks the history one
// entry per cycle and then runs a restoring division one quotient bit per cycle.
// s_axis_tready is high only while the sequencer is idle. The result sits in an output
// register, so a new request is taken while it waits; if the receiver still stalls when
// the next result is done, the sequencer holds it until the register frees up.
// Reset clears all valid marks, the column and the threshold to -3000 m at once;
// the history memory itself is not cleared and needs no clearing pass.
`include "per_satellite_history_mean_core_macros.svh"

module per_satellite_history_mean_core
  import pshm_pkg::*;
#(
  parameter int HISTORY_DEPTH   = DEPTH_DEFAULT,
  parameter int SATELLITE_SLOTS = SLOTS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // sat_id, correction
  input  logic                 s_axis_tuser_i,   // operation
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // out_sat_id, mean_correction, sample_count
  output logic                 m_axis_tuser_o,   // no_mean
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CORR_W-1:0]    cfg_data_i
);

  localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int COL_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SAT_IW    = (SATELLITE_SLOTS > 1) ? $clog2(SATELLITE_SLOTS) : 1;
  localparam int MEM_DEPTH = SATELLITE_SLOTS * HISTORY_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SUM_W     = CORR_W + CNT_W;
  localparam int DIV_W     = $clog2(SUM_W);

  state_e state_q, state_d;

  logic signed [CORR_W-1:0] thr_q;
  logic [COL_W-1:0]         col_q;
  logic [SATELLITE_SLOTS-1:0] mask_q [HISTORY_DEPTH];

  logic [CORR_W-1:0] hist_mem [MEM_DEPTH];
  logic [CORR_W-1:0] rd_data_q;
  logic              rd_vld_q;

  logic [SAT_W-1:0]  sat_q;
  logic [CNT_W-1:0]  k_q;
  logic [CNT_W-1:0]  n_q;
  logic [SUM_W-1:0]  acc_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DIV_W-1:0]  div_cnt_q;
  logic              neg_q;

  logic                  m_valid_q;
  logic [M_TDATA_W-1:0]  m_data_q;
  logic                  m_user_q;

  logic                     s_fire;
  logic                     in_range;
  logic [SAT_W-1:0]         s_sat;
  logic signed [CORR_W-1:0] s_corr;
  logic                     out_free;
  logic                     take_sample;
  logic                     take_epoch;
  logic [COL_W-1:0]         col_next;
  logic [SAT_IW-1:0]        s_sat_idx;
  logic [SAT_IW-1:0]        sat_idx;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic [COL_W-1:0]         k_idx;
  logic                     k_last;

  logic [SUM_W-1:0] add_a;
  logic [SUM_W-1:0] add_b;
  logic             add_sub;
  logic [SUM_W:0]   add_res;
  logic [CNT_W:0]   trial;
  logic             div_ge;

  logic [CORR_W-1:0]    res_mean;
  logic [CNT_OUT_W-1:0] res_cnt;
  logic                 res_none;

  assign s_sat     = s_axis_tdata_i[S_SAT_LO +: SAT_W];
  assign s_corr    = $signed(s_axis_tdata_i[S_CORR_LO +: CORR_W]);
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range  = 32'(s_sat) < SATELLITE_SLOTS;
  assign take_sample = s_fire && (op_e'(s_axis_tuser_i) == OP_SAMPLE) && in_range;
  assign take_epoch  = s_fire && (op_e'(s_axis_tuser_i) == OP_EPOCH);
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  assign col_next  = (32'(col_q) == HISTORY_DEPTH - 1) ? '0 : col_q + COL_W'(1);
  assign s_sat_idx = SAT_IW'(s_sat);
  assign sat_idx   = SAT_IW'(sat_q);
  assign k_last    = (k_q == CNT_W'(HISTORY_DEPTH));
  assign k_idx     = k_last ? '0 : COL_W'(k_q);
  assign wr_addr   = ADDR_W'(s_sat) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(col_q);
  assign rd_addr   = ADDR_W'(sat_q) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(k_idx);

  assign trial   = {rem_q, acc_q[SUM_W-1]};
  assign add_res = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (SUM_W + 1)'(add_sub);
  assign div_ge  = add_res[SUM_W];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (take_sample) state_d = ST_SCAN;
      ST_SCAN:  if (k_last) state_d = ST_ABS;
      ST_ABS:   state_d = (n_q == '0) ? ST_DONE : ST_ROUND;
      ST_ROUND: state_d = ST_DIV;
      ST_DIV:   if (div_cnt_q == DIV_W'(SUM_W - 1)) state_d = ST_NEG;
      ST_NEG:   state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Handshake and shared adder operands.
  always_comb begin
    s_axis_tready_o = 1'b0;
    add_a   = acc_q;
    add_b   = {{(SUM_W - CORR_W){rd_data_q[CORR_W-1]}}, rd_data_q};
    add_sub = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_SCAN:  ;
      ST_ABS, ST_NEG: begin
        add_a   = '0;
        add_b   = acc_q;
        add_sub = 1'b1;
      end
      ST_ROUND: add_b = SUM_W'(n_q >> 1);
      ST_DIV: begin
        add_a   = SUM_W'(trial);
        add_b   = SUM_W'(n_q);
        add_sub = 1'b1;
      end
      ST_DONE:  ;
      default:  ;
    endcase
  end

  assign res_none = (n_q == '0);
  assign res_mean = res_none ? '0 : acc_q[CORR_W-1:0];
  assign res_cnt  = (32'(n_q) > CNT_OUT_MAX) ? CNT_OUT_W'(CNT_OUT_MAX) : CNT_OUT_W'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      thr_q     <= THRESH_RESET;
      col_q     <= '0;
      m_valid_q <= 1'b0;
      for (int c = 0; c < HISTORY_DEPTH; c++) begin
        mask_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= $signed(cfg_data_i);
      end
      if (take_epoch) begin
        col_q          <= col_next;
        mask_q[col_next] <= '0;
      end
      if (take_sample) begin
        mask_q[col_q][s_sat_idx] <= (s_corr > thr_q);
      end
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_sample) begin
      hist_mem[wr_addr] <= s_corr;
    end
    if (state_q == ST_SCAN) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        sat_q     <= s_sat;
        k_q       <= '0;
        n_q       <= '0;
        acc_q     <= '0;
        rem_q     <= '0;
        div_cnt_q <= '0;
        neg_q     <= 1'b0;
      end
      ST_SCAN: begin
        rd_vld_q <= !k_last && mask_q[k_idx][sat_idx];
        if (k_q != '0 && rd_vld_q) begin
          acc_q <= add_res[SUM_W-1:0];
          n_q   <= n_q + CNT_W'(1);
        end
        if (!k_last) begin
          k_q <= k_q + CNT_W'(1);
        end
      end
      ST_ABS: begin
        neg_q <= acc_q[SUM_W-1];
        if (acc_q[SUM_W-1]) begin
          acc_q <= add_res[SUM_W-1:0];
        end
      end
      ST_ROUND: acc_q <= add_res[SUM_W-1:0];
      ST_DIV: begin
        acc_q     <= {acc_q[SUM_W-2:0], div_ge};
        rem_q     <= div_ge ? add_res[CNT_W-1:0] : trial[CNT_W-1:0];
        div_cnt_q <= div_cnt_q + DIV_W'(1);
      end
      ST_NEG: begin
        if (neg_q) begin
          acc_q <= add_res[SUM_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_data_q <= {(M_TDATA_W - M_USED_W)'(0), res_cnt, res_mean, sat_q};
          m_user_q <= res_none;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  `PSHM_ASSERT(a_sample_starts_scan, take_sample |=> state_q == ST_SCAN, "sample not started")
  `PSHM_ASSERT(a_result_from_done, $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_DONE,
               "result without finished sequence")
  `PSHM_ASSERT(a_no_mean_zero,
               m_axis_tvalid_o && m_axis_tuser_o |->
               m_axis_tdata_o[M_CNT_LO +: CNT_OUT_W] == '0 &&
               m_axis_tdata_o[M_MEAN_LO +: CORR_W] == '0,
               "empty result carries data")
  `PSHM_ASSERT_ALWAYS(a_col_range, !rst_ni || 32'(col_q) < HISTORY_DEPTH,
                      "column out of range")

endmodule

FILE: tb/tb_per_satellite_history_mean_core.sv
`timescale 1ns / 1ps

module tb_per_satellite_history_mean_core;
  import pshm_pkg::*;

  localparam int HISTORY_DEPTH   = 8;
  localparam int SATELLITE_SLOTS = 64;
  localparam int RESULT_LATENCY  = 64;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASE_ITEMS     = 250;
  localparam logic signed [CORR_W-1:0] CORR_MAX = 32'sh7fffffff;
  localparam logic signed [CORR_W-1:0] CORR_MIN = 32'sh80000000;

  typedef struct packed {
    logic [SAT_W-1:0]         sat;
    logic signed [CORR_W-1:0] mean;
    logic [CNT_OUT_W-1:0]     count;
    logic                     no_mean;
  } mean_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                 s_axis_tuser_i = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CORR_W-1:0]    cfg_data_i = '0;

  logic signed [CORR_W-1:0] hist_store [SATELLITE_SLOTS][HISTORY_DEPTH];
  logic [SATELLITE_SLOTS-1:0] col_valid [HISTORY_DEPTH];
  int unsigned                write_col = 0;
  logic signed [CORR_W-1:0]   threshold = THRESH_RESET;

  mean_result_t pending_means[$];
  int           failures = 0;
  int           cycle_count = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_stalls_on = 1'b1;
  int           rx_hold_left = 0;
  int           rx_stall_left = 0;
  logic [SAT_W-1:0] hot_sats [4];

  per_satellite_history_mean_core #(
    .HISTORY_DEPTH  (HISTORY_DEPTH),
    .SATELLITE_SLOTS(SATELLITE_SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Updates the shadow history for one accepted request and queues the mean it causes.
  task automatic compute_history_mean(op_e op, logic [SAT_W-1:0] sat,
                                      logic signed [CORR_W-1:0] corr);
    longint       total;
    longint       cnt;
    longint       q;
    mean_result_t res;
    if (op == OP_EPOCH) begin
      write_col = (write_col + 1) % HISTORY_DEPTH;
      col_valid[write_col] = '0;
    end else if (sat < SATELLITE_SLOTS) begin
      hist_store[sat][write_col] = corr;
      col_valid[write_col][sat] = (corr > threshold);
      total = 0;
      cnt = 0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        if (col_valid[k][sat]) begin
          total += longint'(hist_store[sat][k]);
          cnt++;
        end
      end
      res.sat = sat;
      if (cnt == 0) begin
        res.mean = '0;
        res.count = '0;
        res.no_mean = 1'b1;
      end else begin
        if (total >= 0) begin
          q = (total + cnt / 2) / cnt;
        end else begin
          q = -((-total + cnt / 2) / cnt);
        end
        res.mean = q[CORR_W-1:0];
        res.count = CNT_OUT_W'((cnt > CNT_OUT_MAX) ? longint'(CNT_OUT_MAX) : cnt);
        res.no_mean = 1'b0;
      end
      pending_means = {pending_means, res};
    end
  endtask

  task automatic send_request(op_e op, logic [SAT_W-1:0] sat, logic signed [CORR_W-1:0] corr);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = op;
    s_axis_tdata_i = '0;
    s_axis_tdata_i[S_SAT_LO +: SAT_W] = sat;
    s_axis_tdata_i[S_CORR_LO +: CORR_W] = corr;
    do @(posedge clk_i); while (!s_axis_tready_o);
    compute_history_mean(op, sat, corr);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_means.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_threshold(logic signed [CORR_W-1:0] value);
    wait_for_results();
    repeat (RESULT_LATENCY) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [CORR_W-1:0] pick_correction();
    int unsigned r;
    longint      v;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return CORR_MAX;
    end
    if (r < 10) begin
      return CORR_MIN;
    end
    if (r < 35) begin
      v = longint'(threshold) + longint'($urandom_range(0, 8)) - 4;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
      end
      return v[CORR_W-1:0];
    end
    if (r < 65) begin
      return $urandom;
    end
    return $urandom_range(0, 200000) - 100000;
  endfunction

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready_i = 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      m_axis_tready_i = 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready_i = 1'b1;
      if (rx_stalls_on) begin
        rx_stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    mean_result_t got;
    mean_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.sat = m_axis_tdata_o[M_SAT_LO +: SAT_W];
      got.mean = m_axis_tdata_o[M_MEAN_LO +: CORR_W];
      got.count = m_axis_tdata_o[M_CNT_LO +: CNT_OUT_W];
      got.no_mean = m_axis_tuser_o;
      if (pending_means.size() == 0) begin
        note_failure($sformatf("unexpected result: sat %0d mean %0d count %0d no_mean %0b",
                               got.sat, got.mean, got.count, got.no_mean));
      end else begin
        want = pending_means.pop_front();
        if (got.sat !== want.sat || got.mean !== want.mean || got.count !== want.count ||
            got.no_mean !== want.no_mean) begin
          note_failure($sformatf(
              "mismatch: sat %0d/%0d mean %0d/%0d count %0d/%0d no_mean %0b/%0b (exp/act)",
              want.sat, got.sat, want.mean, got.mean, want.count, got.count,
              want.no_mean, got.no_mean));
        end
      end
    end
  end

  task automatic test_extremes_and_overwrite();
    send_request(OP_SAMPLE, 6'd0, CORR_MAX);
    send_request(OP_SAMPLE, 6'd63, CORR_MIN);
    send_request(OP_SAMPLE, 6'd42, THRESH_RESET);
    send_request(OP_SAMPLE, 6'd42, THRESH_RESET + 1);
    send_request(OP_SAMPLE, 6'd42, 32'sd5);
  endtask

  task automatic test_rounding_ties();
    send_request(OP_SAMPLE, 6'd9, 32'sd1);
    send_request(OP_SAMPLE, 6'd10, -32'sd1);
    send_request(OP_EPOCH, 6'd0, 32'sd0);
    send_request(OP_SAMPLE, 6'd9, 32'sd2);
    send_request(OP_SAMPLE, 6'd10, -32'sd2);
  endtask

  task automatic test_full_ring_and_wrap();
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      send_request(OP_EPOCH, 6'h3f, CORR_MIN);
      send_request(OP_SAMPLE, 6'd0, CORR_MAX);
    end
  endtask

  task automatic test_threshold_extremes();
    write_threshold(CORR_MIN);
    send_request(OP_SAMPLE, 6'd63, CORR_MIN);
    send_request(OP_SAMPLE, 6'd63, CORR_MIN + 1);
    write_threshold(CORR_MAX);
    send_request(OP_SAMPLE, 6'd0, CORR_MAX);
    send_request(OP_SAMPLE, 6'd21, CORR_MAX);
    write_threshold(THRESH_RESET);
  endtask

  task automatic test_random_traffic();
    logic signed [CORR_W-1:0] floors [5];
    logic [SAT_W-1:0]         sat;
    floors[0] = THRESH_RESET;
    floors[1] = $urandom;
    floors[2] = '0;
    floors[3] = CORR_MIN;
    floors[4] = $urandom_range(0, 2000) - 1000;
    for (int p = 0; p < 5; p++) begin
      write_threshold(floors[p]);
      tx_gaps_on = (p % 2) == 0;
      rx_stalls_on = (p != 2);
      for (int h = 0; h < 4; h++) begin
        hot_sats[h] = SAT_W'($urandom_range(0, SATELLITE_SLOTS - 1));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 70) begin
          sat = hot_sats[$urandom_range(0, 3)];
        end else begin
          sat = SAT_W'($urandom_range(0, SATELLITE_SLOTS - 1));
        end
        if ($urandom_range(0, 11) == 0) begin
          send_request(OP_EPOCH, sat, $urandom);
        end else begin
          send_request(OP_SAMPLE, sat, pick_correction());
        end
      end
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    wait_for_results();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_left = 400;
    for (int i = 0; i < 12; i++) begin
      send_request(OP_SAMPLE, SAT_W'($urandom_range(0, 3)), pick_correction());
    end
    wait_for_results();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_request(OP_SAMPLE, SAT_W'($urandom_range(0, 3)), pick_correction());
    end
  endtask

  initial begin
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      col_valid[k] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes_and_overwrite();
    test_rounding_ties();
    test_full_ring_and_wrap();
    test_threshold_extremes();
    test_random_traffic();
    test_output_backpressure();
    wait_for_results();
    repeat (RESULT_LATENCY) @(negedge clk_i);
    if (pending_means.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_means.size()));
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
